// ===== rtl/accumulator_cpu_step_top_defines.svh =====
// Assertion macros shared by the accumulator step RTL.
`ifndef ACCUMULATOR_CPU_STEP_TOP_DEFINES_SVH
`define ACCUMULATOR_CPU_STEP_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on aclk, ignored while reset is held.
`define ACS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Check a property on aclk, also during reset.
`define ACS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define ACS_ASSERT(lbl, prop, msg)
`define ACS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/acs_pkg.sv =====
// Types, codes and sizes shared by the accumulator step design.
`default_nettype none

package acs_pkg;

    // Data RAM and program space are powers of two; addresses wrap by truncation.
    localparam int RAM_AW    = 8;
    localparam int RAM_WORDS = 1 << RAM_AW;
    localparam int PC_W      = 8;
    localparam int DATA_W    = 32;
    localparam int DIV_CNT_W = $clog2(DATA_W);

    localparam logic [1:0] ACT_EXEC  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [3:0] OP_HALT      = 4'd0;
    localparam logic [3:0] OP_ADD       = 4'd1;
    localparam logic [3:0] OP_SUB       = 4'd2;
    localparam logic [3:0] OP_MUL       = 4'd3;
    localparam logic [3:0] OP_DIV       = 4'd4;
    localparam logic [3:0] OP_STORE     = 4'd5;
    localparam logic [3:0] OP_LOAD      = 4'd6;
    localparam logic [3:0] OP_IMM       = 4'd7;
    localparam logic [3:0] OP_STORE_ALT = 4'd8;
    localparam logic [3:0] OP_JMP       = 4'd9;
    localparam logic [3:0] OP_JZ        = 4'd10;
    localparam logic [3:0] OP_JNZ       = 4'd11;
    localparam logic [3:0] OP_JGT       = 4'd12;

    localparam logic [7:0] SEL_ONE = 8'd1;
    localparam logic [7:0] SEL_TWO = 8'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH_A,
        S_FETCH_B,
        S_EXEC,
        S_DIV,
        S_WB,
        S_FIN
    } state_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [3:0]         opcode;
        logic [7:0]         operand_one;
        logic signed [31:0] operand_two;
        logic [7:0]         operand_three;
    } in_word_t;

    typedef struct packed {
        logic [7:0]         program_counter;
        logic signed [31:0] accumulator;
        logic signed [31:0] reg_first;
        logic signed [31:0] reg_second;
        logic [3:0]         current_opcode;
        logic               halted;
        logic               divide_error;
        logic signed [31:0] read_word;
    } out_word_t;

    typedef struct packed {
        logic              we;
        logic [RAM_AW-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [RAM_AW-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

// ===== rtl/acs_ram.sv =====
// Data RAM: one write port, one registered read port, per-word valid bits.
`default_nettype none

module acs_ram (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire acs_pkg::ram_req_t         req,
    output logic [acs_pkg::DATA_W-1:0]     rdata
);
    import acs_pkg::*;

    logic [DATA_W-1:0]    mem [RAM_WORDS];
    logic [RAM_WORDS-1:0] valid_reg;
    logic [DATA_W-1:0]    rdata_reg;
    logic                 rvalid_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    // A word never written since reset reads as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            rvalid_reg <= valid_reg[req.raddr];
            if (req.we) begin
                valid_reg[req.waddr] <= 1'b1;
            end
        end
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

`default_nettype wire

// ===== rtl/acs_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating.
`default_nettype none
`include "accumulator_cpu_step_top_defines.svh"

module acs_div (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [acs_pkg::DATA_W-1:0] dividend,
    input  wire logic [acs_pkg::DATA_W-1:0] divisor,
    output acs_pkg::div_status_t           status,
    output logic [acs_pkg::DATA_W-1:0]     quotient
);
    import acs_pkg::*;

    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DATA_W - 1);

    logic [DATA_W-1:0]    quo_reg;
    logic [DATA_W-1:0]    rem_reg;
    logic [DATA_W-1:0]    den_reg;
    logic                 neg_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DATA_W:0]      trial;

    assign trial = {rem_reg, quo_reg[DATA_W-1]} - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Work on magnitudes; fix the sign at the output.
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend[DATA_W-1] ? (-dividend) : dividend;
            den_reg <= divisor[DATA_W-1] ? (-divisor) : divisor;
            rem_reg <= '0;
            neg_reg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DATA_W-2:0], ~trial[DATA_W]};
            rem_reg <= trial[DATA_W] ? {rem_reg[DATA_W-2:0], quo_reg[DATA_W-1]}
                                     : trial[DATA_W-1:0];
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = neg_reg ? (-quo_reg) : quo_reg;

    `ACS_ASSERT(a_div_start_idle, start |-> !busy_reg, "divider restarted while busy")
    `ACS_ASSERT(a_div_done_pulse, done_reg |=> !done_reg, "divider done held two cycles")
    `ACS_ASSERT(a_div_finish, (busy_reg && !start && cnt_reg == DIV_LAST) |=> done_reg,
        "divider missed its last step")

endmodule

`default_nettype wire

// ===== rtl/accumulator_cpu_step_top.sv =====
// Top level of the accumulator step: sequencer, register file and datapath.
`default_nettype none
`include "accumulator_cpu_step_top_defines.svh"

// Executes one word per handshake of a small three-address memory machine, or
// loads or reads one data RAM word directly. Each accepted word walks through
// a sequence: two reads through the data RAM read port (registered), execute,
// for a signed divide with nonzero divisor a wait on the one-bit-per-cycle
// divider, write back, then the result word is loaded into the output register;
// that load waits while an earlier result there is not taken. s_ready is high only
// while no word is in flight, but a finished result waiting in the output
// register does not block the next acceptance. The data RAM reads as zero
// after reset through one valid bit per word, so no clearing pass is needed.
// Addresses wrap modulo the RAM size and jump targets modulo program size.

module accumulator_cpu_step_top (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire acs_pkg::in_word_t   s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output acs_pkg::out_word_t       m_data
);
    import acs_pkg::*;

    state_t            state_reg;
    state_t            state_next;
    in_word_t          item_reg;
    logic [DATA_W-1:0] opa_reg;

    // Architectural state.
    logic [PC_W-1:0]   pc_reg;
    logic [PC_W-1:0]   pc_next;
    logic [DATA_W-1:0] acc_reg;
    logic [DATA_W-1:0] gp_one_reg;
    logic [DATA_W-1:0] gp_two_reg;
    logic [3:0]        instr_reg;
    logic              halted_reg;
    logic              derr_reg;

    out_word_t         out_reg;
    logic              m_valid_reg;
    logic              out_load;

    ram_req_t          ram_req;
    logic [DATA_W-1:0] ram_rdata;
    logic              div_start;
    div_status_t       div_stat;
    logic [DATA_W-1:0] div_quot;

    // Decode of the word held in item_reg.
    logic              is_exec;
    logic              is_arith;
    logic              is_store;
    logic              sel_valid;
    logic              div_zero;
    logic              take_jump;
    logic [3:0]        op;

    assign op        = item_reg.opcode;
    assign is_exec   = (item_reg.action == ACT_EXEC);
    assign is_arith  = is_exec && (op == OP_ADD || op == OP_SUB || op == OP_MUL ||
                                   op == OP_DIV);
    assign is_store  = is_exec && (op == OP_STORE || op == OP_STORE_ALT);
    assign sel_valid = (item_reg.operand_one == SEL_ONE) ||
                       (item_reg.operand_one == SEL_TWO);
    // Second operand arrives from the RAM during execute.
    assign div_zero  = (op == OP_DIV) && (ram_rdata == '0);

    always_comb begin
        take_jump = 1'b0;
        unique case (op)
            OP_JMP:  take_jump = 1'b1;
            OP_JZ:   take_jump = (acc_reg == '0);
            OP_JNZ:  take_jump = (acc_reg != '0);
            OP_JGT:  take_jump = (acc_reg != '0) && !acc_reg[DATA_W-1];
            default: take_jump = 1'b0;
        endcase
    end

    always_comb begin
        priority if (take_jump) begin
            pc_next = PC_W'(item_reg.operand_one);
        end else if (div_zero) begin
            pc_next = pc_reg;
        end else begin
            pc_next = pc_reg + 1'b1;
        end
    end

    // Sequencer: next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (s_valid) state_next = S_FETCH_A;
            S_FETCH_A: state_next = S_FETCH_B;
            S_FETCH_B: state_next = S_EXEC;
            S_EXEC: begin
                if (is_exec && op == OP_DIV && !div_zero) state_next = S_DIV;
                else state_next = S_WB;
            end
            S_DIV:     if (div_stat.done) state_next = S_WB;
            S_WB:      state_next = S_FIN;
            S_FIN:     if (!m_valid_reg || m_ready) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // Sequencer: outputs, RAM port and divider start.
    always_comb begin
        s_ready       = 1'b0;
        out_load      = 1'b0;
        div_start     = 1'b0;
        ram_req.we    = 1'b0;
        ram_req.waddr = RAM_AW'(item_reg.operand_three);
        ram_req.wdata = acc_reg;
        ram_req.raddr = RAM_AW'(item_reg.operand_one);
        unique case (state_reg)
            S_IDLE: s_ready = 1'b1;
            S_FETCH_A: begin
                // First read: source one, load address, or direct read address.
                priority if (item_reg.action == ACT_READ) begin
                    ram_req.raddr = RAM_AW'(item_reg.operand_three);
                end else if (is_exec && op == OP_LOAD) begin
                    ram_req.raddr = RAM_AW'(item_reg.operand_two);
                end else begin
                    ram_req.raddr = RAM_AW'(item_reg.operand_one);
                end
            end
            S_FETCH_B: ram_req.raddr = RAM_AW'(item_reg.operand_two);
            S_EXEC:    div_start = is_exec && (op == OP_DIV) && !div_zero;
            S_DIV:     ;
            S_WB: begin
                priority if (item_reg.action == ACT_WRITE) begin
                    ram_req.we    = 1'b1;
                    ram_req.wdata = item_reg.operand_two;
                end else if (is_arith) begin
                    // Drop the store after a divide by zero.
                    ram_req.we = !derr_reg;
                end else if (is_store) begin
                    ram_req.we    = sel_valid;
                    ram_req.waddr = RAM_AW'(item_reg.operand_two);
                    ram_req.wdata = (item_reg.operand_one == SEL_ONE) ? gp_one_reg
                                                                      : gp_two_reg;
                end else begin
                    ram_req.we = 1'b0;
                end
            end
            S_FIN:   out_load = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Hold the accepted word and the first RAM operand.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
        if (state_reg == S_FETCH_B) begin
            opa_reg <= ram_rdata;
        end
    end

    // Execute: update registers, accumulator, program counter and flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg     <= '0;
            acc_reg    <= '0;
            gp_one_reg <= '0;
            gp_two_reg <= '0;
            instr_reg  <= '0;
            halted_reg <= 1'b0;
            derr_reg   <= 1'b0;
        end else if (state_reg == S_EXEC) begin
            halted_reg <= 1'b0;
            derr_reg   <= 1'b0;
            if (is_exec) begin
                instr_reg <= op;
                pc_reg    <= pc_next;
                unique case (op)
                    OP_HALT: halted_reg <= 1'b1;
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                        gp_one_reg <= opa_reg;
                        gp_two_reg <= ram_rdata;
                        unique case (op)
                            OP_ADD:  acc_reg <= opa_reg + ram_rdata;
                            OP_SUB:  acc_reg <= opa_reg - ram_rdata;
                            OP_MUL:  acc_reg <= opa_reg * ram_rdata;
                            default: begin
                                if (div_zero) begin
                                    acc_reg  <= '0;
                                    derr_reg <= 1'b1;
                                end
                            end
                        endcase
                    end
                    OP_LOAD: begin
                        if (item_reg.operand_one == SEL_ONE) gp_one_reg <= opa_reg;
                        else if (item_reg.operand_one == SEL_TWO) gp_two_reg <= opa_reg;
                    end
                    OP_IMM: begin
                        if (item_reg.operand_one == SEL_ONE) begin
                            gp_one_reg <= item_reg.operand_two;
                        end else if (item_reg.operand_one == SEL_TWO) begin
                            gp_two_reg <= item_reg.operand_two;
                        end
                    end
                    default: ;
                endcase
            end
        end else if (state_reg == S_DIV && div_stat.done) begin
            acc_reg <= div_quot;
        end
    end

    // Result register: load at the end of the sequence, hold until taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg.program_counter <= 8'(pc_reg);
            out_reg.accumulator     <= acc_reg;
            out_reg.reg_first       <= gp_one_reg;
            out_reg.reg_second      <= gp_two_reg;
            out_reg.current_opcode  <= instr_reg;
            out_reg.halted          <= halted_reg;
            out_reg.divide_error    <= derr_reg;
            out_reg.read_word       <= (item_reg.action == ACT_READ) ? opa_reg : '0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    acs_ram u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ram_req),
        .rdata   (ram_rdata)
    );

    acs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (opa_reg),
        .divisor  (ram_rdata),
        .status   (div_stat),
        .quotient (div_quot)
    );

    `ACS_ASSERT(a_wb_only_write, ram_req.we |-> state_reg == S_WB,
        "RAM written outside write back")
    `ACS_ASSERT(a_div_wait, state_reg == S_DIV |-> (div_stat.busy || div_stat.done),
        "waiting on an idle divider")
    `ACS_ASSERT(a_fin_delivers, (state_reg == S_FIN && (!m_valid_reg || m_ready)) |=>
        (m_valid_reg && state_reg == S_IDLE), "finished word not presented")
    `ACS_ASSERT_ALWAYS(a_flags_exclusive, !aresetn || !(halted_reg && derr_reg),
        "halt and divide error flagged together")

endmodule

`default_nettype wire

// ===== tb/sv/accumulator_cpu_step_top_tb.sv =====
// Self-checking testbench for the accumulator step block: directed words, then random programs.
`timescale 1ns / 1ps

module accumulator_cpu_step_top_tb;
    import acs_pkg::*;

    // Run limits. The slowest word is a divide; even with input gaps and result stalls
    // on top, ~1350 words fit well within LIMIT_CYCLES.
    localparam int          LIMIT_CYCLES  = 400000;
    localparam int          SETTLE_CYCLES = 60;
    localparam int          RANDOM_WORDS  = 1100;
    localparam int          STREAM_WORDS  = 200;

    // Opcodes with no function, and a register select that matches neither register.
    localparam logic [3:0]  OP_SPARE_LO   = 4'd13;
    localparam logic [3:0]  OP_SPARE_HI   = 4'd15;
    localparam logic [7:0]  SEL_NONE      = 8'd0;

    localparam logic [31:0] WORD_MIN      = 32'h8000_0000;
    localparam logic [31:0] WORD_MAX      = 32'h7FFF_FFFF;
    localparam logic [31:0] WORD_ALL_ONES = 32'hFFFF_FFFF;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;

    // Machine state as the testbench sees it: updated once per accepted word.
    logic [PC_W-1:0]   mach_pc;
    logic [DATA_W-1:0] mach_acc;
    logic [DATA_W-1:0] mach_r1;
    logic [DATA_W-1:0] mach_r2;
    logic [3:0]        mach_ir;
    logic [DATA_W-1:0] mach_ram [RAM_WORDS];

    // Result words still owed by the block, oldest first.
    out_word_t expected_words[$];

    int fail_count   = 0;
    int cycle_count  = 0;
    int stall_left   = 0;
    bit idle_on      = 1'b0;

    accumulator_cpu_step_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Signed divide on magnitudes, truncating toward zero; MIN / -1 wraps to MIN.
    function automatic logic [31:0] trunc_quotient(logic [31:0] num, logic [31:0] den);
        logic [31:0] num_mag;
        logic [31:0] den_mag;
        logic [31:0] quot;
        num_mag = num[31] ? -num : num;
        den_mag = den[31] ? -den : den;
        quot    = num_mag / den_mag;
        return (num[31] ^ den[31]) ? -quot : quot;
    endfunction

    // Apply one accepted word to the machine state and build the result word it owes.
    function automatic out_word_t execute_word(in_word_t w);
        out_word_t       res;
        logic            advance;
        logic            take;
        logic [RAM_AW-1:0] addr_two;
        res      = '0;
        addr_two = w.operand_two[RAM_AW-1:0];
        if (w.action == ACT_EXEC) begin
            advance = 1'b1;
            mach_ir = w.opcode;
            case (w.opcode)
                OP_HALT: begin
                    res.halted = 1'b1;
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                    mach_r1 = mach_ram[w.operand_one[RAM_AW-1:0]];
                    mach_r2 = mach_ram[addr_two];
                    if (w.opcode == OP_DIV && mach_r2 == '0) begin
                        // divide by zero: clear acc, skip the store, hold PC
                        mach_acc         = '0;
                        res.divide_error = 1'b1;
                        advance          = 1'b0;
                    end else begin
                        case (w.opcode)
                            OP_ADD:  mach_acc = mach_r1 + mach_r2;
                            OP_SUB:  mach_acc = mach_r1 - mach_r2;
                            OP_MUL:  mach_acc = mach_r1 * mach_r2;
                            default: mach_acc = trunc_quotient(mach_r1, mach_r2);
                        endcase
                        mach_ram[w.operand_three[RAM_AW-1:0]] = mach_acc;
                    end
                end
                OP_STORE, OP_STORE_ALT: begin
                    if (w.operand_one == SEL_ONE) mach_ram[addr_two] = mach_r1;
                    else if (w.operand_one == SEL_TWO) mach_ram[addr_two] = mach_r2;
                end
                OP_LOAD: begin
                    if (w.operand_one == SEL_ONE) mach_r1 = mach_ram[addr_two];
                    else if (w.operand_one == SEL_TWO) mach_r2 = mach_ram[addr_two];
                end
                OP_IMM: begin
                    if (w.operand_one == SEL_ONE) mach_r1 = w.operand_two;
                    else if (w.operand_one == SEL_TWO) mach_r2 = w.operand_two;
                end
                OP_JMP: begin
                    mach_pc = w.operand_one;
                    advance = 1'b0;
                end
                OP_JZ, OP_JNZ, OP_JGT: begin
                    case (w.opcode)
                        OP_JZ:   take = (mach_acc == '0);
                        OP_JNZ:  take = (mach_acc != '0);
                        default: take = (mach_acc != '0) && !mach_acc[31];
                    endcase
                    if (take) begin
                        mach_pc = w.operand_one;
                        advance = 1'b0;
                    end
                end
                default: begin
                end
            endcase
            if (advance) mach_pc = mach_pc + 1'b1;
        end else if (w.action == ACT_WRITE) begin
            mach_ram[w.operand_three[RAM_AW-1:0]] = w.operand_two;
        end else if (w.action == ACT_READ) begin
            res.read_word = mach_ram[w.operand_three[RAM_AW-1:0]];
        end
        res.program_counter = mach_pc;
        res.accumulator     = mach_acc;
        res.reg_first       = mach_r1;
        res.reg_second      = mach_r2;
        res.current_opcode  = mach_ir;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            $error("%s: expected %h, got %h", name, want, got);
        end
    endtask

    // Compare every result word taken at a rising edge with the oldest expectation.
    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                fail_count++;
                $error("result word with no expectation pending");
            end else begin
                want = expected_words.pop_front();
                check_field("program_counter", 32'(want.program_counter),
                            32'(m_data.program_counter));
                check_field("accumulator", want.accumulator, m_data.accumulator);
                check_field("reg_first", want.reg_first, m_data.reg_first);
                check_field("reg_second", want.reg_second, m_data.reg_second);
                check_field("current_opcode", 32'(want.current_opcode),
                            32'(m_data.current_opcode));
                check_field("halted", 32'(want.halted), 32'(m_data.halted));
                check_field("divide_error", 32'(want.divide_error),
                            32'(m_data.divide_error));
                check_field("read_word", want.read_word, m_data.read_word);
            end
        end
    end

    // Hard stop if the block hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: drop ready in random bursts while idling is on.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            m_ready <= 1'b0;
            stall_left = $urandom_range(0, 3);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic in_word_t make_word(logic [1:0] act, logic [3:0] op, logic [7:0] one,
                                           logic [31:0] two, logic [7:0] three);
        in_word_t w;
        w.action        = act;
        w.opcode        = op;
        w.operand_one   = one;
        w.operand_two   = two;
        w.operand_three = three;
        return w;
    endfunction

    // Present one word at a falling edge, hold it until accepted, then predict its result.
    // Valid stays high afterwards; the next send or a drain replaces or lowers it at the
    // very next falling edge, so no word is taken twice.
    task automatic send_word(in_word_t w);
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_words.push_back(execute_word(w));
    endtask

    // Lower valid and wait until every owed result has come back.
    task automatic wait_for_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
    endtask

    // Data words weighted toward the extremes and small signed values.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return WORD_MIN;
            2:       return WORD_MAX;
            3:       return WORD_ALL_ONES;
            4:       return $urandom_range(1, 9);
            5:       return -$urandom_range(1, 9);
            default: return $urandom;
        endcase
    endfunction

    // Addresses mostly land in a small window so words get reused; high bits vary anyway.
    function automatic logic [31:0] pick_addr();
        logic [31:0] a;
        a = $urandom;
        if ($urandom_range(0, 3) != 0) a[7:0] = 8'($urandom_range(0, 15));
        if ($urandom_range(0, 1) == 0) a[31:8] = '0;
        return a;
    endfunction

    function automatic logic [7:0] pick_sel();
        case ($urandom_range(0, 4))
            0, 1:    return SEL_ONE;
            2, 3:    return SEL_TWO;
            default: return 8'($urandom);
        endcase
    endfunction

    // One random word: mostly well-formed instructions and RAM traffic, some pure noise.
    function automatic in_word_t random_word();
        in_word_t w;
        w.action        = 2'($urandom_range(ACT_EXEC, ACT_READ));
        w.opcode        = 4'($urandom);
        w.operand_one   = 8'($urandom);
        w.operand_two   = $urandom;
        w.operand_three = 8'($urandom);
        if ($urandom_range(0, 9) == 0) return w;
        case ($urandom_range(0, 9))
            0, 1: begin
                w.action        = ACT_WRITE;
                w.operand_two   = pick_value();
                w.operand_three = 8'(pick_addr());
            end
            2: begin
                w.action        = ACT_READ;
                w.operand_three = 8'(pick_addr());
            end
            default: begin
                w.action = ACT_EXEC;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        w.opcode        = 4'($urandom_range(OP_ADD, OP_DIV));
                        w.operand_one   = 8'(pick_addr());
                        w.operand_two   = pick_addr();
                        w.operand_three = 8'(pick_addr());
                    end
                    4: begin
                        w.opcode      = $urandom_range(0, 1) ? OP_STORE : OP_STORE_ALT;
                        w.operand_one = pick_sel();
                        w.operand_two = pick_addr();
                    end
                    5: begin
                        w.opcode      = OP_LOAD;
                        w.operand_one = pick_sel();
                        w.operand_two = pick_addr();
                    end
                    6: begin
                        w.opcode      = OP_IMM;
                        w.operand_one = pick_sel();
                        w.operand_two = pick_value();
                    end
                    7, 8: begin
                        w.opcode = 4'($urandom_range(OP_JMP, OP_JGT));
                    end
                    default: begin
                        w.opcode = $urandom_range(0, 1) ? OP_HALT
                                 : 4'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
                    end
                endcase
            end
        endcase
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Direct RAM loads at both ends of the address space, and a read of a cleared word.
    task automatic test_ram_access();
        send_word(make_word(ACT_WRITE, OP_SPARE_HI, 8'hFF, WORD_MAX, 8'hFF));
        send_word(make_word(ACT_WRITE, OP_HALT, 8'h00, WORD_MIN, 8'h00));
        send_word(make_word(ACT_WRITE, OP_ADD, 8'h00, WORD_ALL_ONES, 8'h01));
        send_word(make_word(ACT_WRITE, OP_ADD, 8'h00, 32'd3, 8'h02));
        send_word(make_word(ACT_READ, OP_HALT, 8'h00, WORD_ALL_ONES, 8'h03));
        wait_for_results();
    endtask

    // Arithmetic on extreme words: divide overflow, truncation and divide by zero.
    task automatic test_arithmetic();
        // address in operand_two carries set high bits that must be ignored
        send_word(make_word(ACT_EXEC, OP_ADD, 8'hFF, 32'hFFFF_FF00, 8'd4));
        send_word(make_word(ACT_EXEC, OP_SUB, 8'h00, 32'd1, 8'd6));
        send_word(make_word(ACT_EXEC, OP_MUL, 8'hFF, 32'd1, 8'd5));
        send_word(make_word(ACT_EXEC, OP_DIV, 8'h00, 32'd1, 8'd7));
        send_word(make_word(ACT_EXEC, OP_DIV, 8'd6, 32'd2, 8'd8));
        send_word(make_word(ACT_EXEC, OP_DIV, 8'd1, 32'd3, 8'd9));
        wait_for_results();
    endtask

    // Immediate, store and load copies, including a select that matches no register.
    task automatic test_register_copies();
        send_word(make_word(ACT_EXEC, OP_IMM, SEL_ONE, WORD_MIN, 8'h00));
        send_word(make_word(ACT_EXEC, OP_IMM, SEL_TWO, WORD_MAX, 8'h00));
        send_word(make_word(ACT_EXEC, OP_IMM, 8'hFF, 32'd5, 8'h00));
        send_word(make_word(ACT_EXEC, OP_STORE, SEL_ONE, 32'hABCD_0010, 8'h00));
        send_word(make_word(ACT_EXEC, OP_STORE_ALT, SEL_TWO, 32'h0000_0011, 8'h00));
        send_word(make_word(ACT_EXEC, OP_LOAD, SEL_TWO, 32'h0000_0010, 8'h00));
        send_word(make_word(ACT_EXEC, OP_LOAD, SEL_NONE, 32'h0000_0011, 8'h00));
        wait_for_results();
    endtask

    // Halt, jumps taken and not taken, PC wrap, and the opcodes with no function.
    // Acc is zero here, left so by the divide by zero above.
    task automatic test_control_flow();
        send_word(make_word(ACT_EXEC, OP_HALT, 8'h00, 32'd0, 8'h00));
        send_word(make_word(ACT_EXEC, OP_JMP, 8'hFF, 32'd0, 8'h00));
        send_word(make_word(ACT_EXEC, OP_SPARE_HI, 8'h00, 32'd0, 8'h00));
        send_word(make_word(ACT_EXEC, OP_JZ, 8'h40, 32'd0, 8'h00));
        send_word(make_word(ACT_EXEC, OP_JNZ, 8'h80, 32'd0, 8'h00));
        send_word(make_word(ACT_EXEC, OP_JGT, 8'hC0, 32'd0, 8'h00));
        send_word(make_word(ACT_EXEC, OP_SPARE_LO, 8'h00, 32'd0, 8'h00));
        wait_for_results();
    endtask

    // Random programs with idle bursts on both sides.
    task automatic test_random_programs(int count);
        idle_on = 1'b1;
        repeat (count) send_word(random_word());
        wait_for_results();
    endtask

    // Random programs back to back: no gaps, no stalls.
    task automatic test_back_to_back(int count);
        idle_on = 1'b0;
        repeat (count) send_word(random_word());
        wait_for_results();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        s_valid  = 1'b0;
        s_data   = '0;
        m_ready  = 1'b0;
        aresetn  = 1'b0;
        mach_pc  = '0;
        mach_acc = '0;
        mach_r1  = '0;
        mach_r2  = '0;
        mach_ir  = '0;
        foreach (mach_ram[i]) mach_ram[i] = '0;

        // hold reset, then release it on a falling edge
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_ram_access();
        test_arithmetic();
        test_register_copies();
        test_control_flow();
        test_random_programs(RANDOM_WORDS);
        test_back_to_back(STREAM_WORDS);

        // let any stray result word show up before the verdict
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && expected_words.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/acs_pkg.sv
rtl/acs_ram.sv
rtl/acs_div.sv
rtl/accumulator_cpu_step_top.sv
tb/sv/accumulator_cpu_step_top_tb.sv
